// ===== src/altitude_climb_slope_tracker_defines.svh =====
// assertion macros for the climb and grade tracker
`ifndef ALTITUDE_CLIMB_SLOPE_TRACKER_DEFINES_SVH
`define ALTITUDE_CLIMB_SLOPE_TRACKER_DEFINES_SVH

// same-cycle implication
`define ACST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acst check failed");

// next-cycle implication
`define ACST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acst check failed");

`endif

// ===== src/acst_pkg.sv =====
package acst_pkg;

   localparam int WINDOW      = 8;
   localparam int SLOT_W      = $clog2(WINDOW);
   localparam int ALT_W       = 18;
   localparam int DIST_W      = 32;
   localparam int ALT_SUM_W   = ALT_W + SLOT_W;
   localparam int DIST_SUM_W  = DIST_W + SLOT_W;
   localparam int ALT_DIFF_W  = ALT_W + 1;
   localparam int DIST_DIFF_W = DIST_W + 1;
   localparam int SLOPE_W     = 14;
   localparam int GRADE_W     = 15;
   localparam int PEAK_ALT_W  = 17;
   localparam int PEAK_GRD_W  = 14;
   localparam int NUM_W       = 29;
   localparam int MAG_W       = NUM_W - 1;
   localparam int LIMIT_W     = SLOPE_W + DIST_W;
   localparam int DIV_CNT_W   = $clog2(MAG_W + 1);

   localparam logic [NUM_W-1:0]   GRADE_SCALE = NUM_W'(1000);
   localparam logic [MAG_W-1:0]   GRADE_LIMIT = MAG_W'(10000);
   localparam logic [SLOPE_W-1:0] SLOPE_RESET = SLOPE_W'(1000);

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_MAX_SLOPE = 1'b0;

   typedef struct packed {
      logic capture;
      logic load;
      logic means;
      logic product;
      logic div_start;
      logic grade;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic grade_ok;
      logic div_done;
   } status_type;

endpackage

// ===== src/acst_divider.sv =====
module acst_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [acst_pkg::MAG_W-1:0]  dividend,
   input  logic [acst_pkg::DIST_W-1:0] divisor,
   output logic [acst_pkg::MAG_W-1:0]  quotient,
   output logic                        done
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [acst_pkg::DIV_CNT_W-1:0]  count_ff, count_in;
   logic [acst_pkg::MAG_W-1:0]      quo_ff, quo_in;
   logic [acst_pkg::DIST_W-1:0]     rem_ff, rem_in;
   logic [acst_pkg::DIST_W:0]       trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, quo_ff[acst_pkg::MAG_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = acst_pkg::DIV_CNT_W'(acst_pkg::MAG_W);
         quo_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = acst_pkg::DIST_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[acst_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[acst_pkg::DIST_W-1:0];
            quo_in = {quo_ff[acst_pkg::MAG_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == acst_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== src/acst_datapath.sv =====
module acst_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  acst_pkg::cmd_type                   cmd,
   output acst_pkg::status_type                status,
   input  logic [acst_pkg::SLOPE_W-1:0]        max_slope,
   input  logic [acst_pkg::DIST_W-1:0]         req_total_distance,
   input  logic signed [acst_pkg::ALT_W-1:0]   req_sensor_altitude,
   output logic signed [acst_pkg::ALT_W-1:0]   rsp_smoothed_altitude,
   output logic signed [acst_pkg::GRADE_W-1:0] rsp_grade,
   output logic [31:0]                         rsp_ascent_total,
   output logic [31:0]                         rsp_descent_total,
   output logic [acst_pkg::PEAK_ALT_W-1:0]     rsp_altitude_peak,
   output logic [acst_pkg::PEAK_GRD_W-1:0]     rsp_grade_peak
);

   logic [acst_pkg::ALT_W-1:0]       alt_win_ff [acst_pkg::WINDOW];
   logic [acst_pkg::DIST_W-1:0]      dist_win_ff [acst_pkg::WINDOW];
   logic [acst_pkg::ALT_SUM_W-1:0]   alt_sum_ff;
   logic [acst_pkg::DIST_SUM_W-1:0]  dist_sum_ff;
   logic [acst_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic                             primed_ff;
   logic [acst_pkg::DIST_W-1:0]      in_dist_ff;
   logic [acst_pkg::ALT_W-1:0]       in_alt_ff;
   logic [acst_pkg::DIST_W-1:0]      prev_dist_ff;
   logic [acst_pkg::ALT_W-1:0]       prev_alt_ff;
   logic [acst_pkg::ALT_W-1:0]       mean_alt_ff;
   logic [acst_pkg::ALT_DIFF_W-1:0]  alt_diff_ff, alt_diff_in;
   logic [acst_pkg::DIST_W-1:0]      mean_dist_ff;
   logic [acst_pkg::DIST_DIFF_W-1:0] dist_diff_ff, dist_diff_in;
   logic                             dist_grow_ff;
   logic [acst_pkg::NUM_W-1:0]       num_ff, num_in;
   logic [acst_pkg::LIMIT_W-1:0]     limit_ff, limit_in;
   logic [31:0]                      climb_ff, climb_in;
   logic [31:0]                      drop_ff, drop_in;
   logic [32:0]                      acc_sum;
   logic [acst_pkg::ALT_DIFF_W-1:0]  drop_mag;
   logic [acst_pkg::GRADE_W-1:0]     grade_ff, grade_in;
   logic [acst_pkg::PEAK_ALT_W-1:0]  peak_alt_ff, peak_alt_in;
   logic [acst_pkg::PEAK_GRD_W-1:0]  peak_grd_ff, peak_grd_in;
   logic [acst_pkg::NUM_W-1:0]       num_mag;
   logic [acst_pkg::MAG_W-1:0]       quotient;
   logic [acst_pkg::MAG_W-1:0]       quo_sat;
   logic                             div_done;

   always_comb begin
      slot_in = (slot_ff == acst_pkg::SLOT_W'(acst_pkg::WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      alt_diff_in = {alt_sum_ff[acst_pkg::ALT_SUM_W-1], alt_sum_ff[acst_pkg::ALT_SUM_W-1:
                     acst_pkg::SLOT_W]} - {prev_alt_ff[acst_pkg::ALT_W-1], prev_alt_ff};
      dist_diff_in = {1'b0, dist_sum_ff[acst_pkg::DIST_SUM_W-1:acst_pkg::SLOT_W]}
                   - {1'b0, prev_dist_ff};
   end

   always_comb begin
      num_in   = acst_pkg::NUM_W'($signed({{(acst_pkg::NUM_W-acst_pkg::ALT_DIFF_W)
                 {alt_diff_ff[acst_pkg::ALT_DIFF_W-1]}}, alt_diff_ff})
                 * $signed(acst_pkg::GRADE_SCALE));
      limit_in = acst_pkg::LIMIT_W'(max_slope)
               * acst_pkg::LIMIT_W'(dist_diff_ff[acst_pkg::DIST_W-1:0]);
      climb_in = climb_ff;
      drop_in  = drop_ff;
      drop_mag = -alt_diff_ff;
      acc_sum  = '0;
      if (!alt_diff_ff[acst_pkg::ALT_DIFF_W-1]) begin
         acc_sum  = {1'b0, climb_ff} + 33'(alt_diff_ff);
         climb_in = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
      end else begin
         acc_sum = {1'b0, drop_ff} + 33'(drop_mag);
         drop_in = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
      end
      peak_alt_in = peak_alt_ff;
      if ($signed(mean_alt_ff) > $signed({1'b0, peak_alt_ff})) begin
         peak_alt_in = mean_alt_ff[acst_pkg::PEAK_ALT_W-1:0];
      end
   end

   always_comb begin
      num_mag  = num_ff[acst_pkg::NUM_W-1] ? -num_ff : num_ff;
      quo_sat  = (quotient > acst_pkg::GRADE_LIMIT) ? acst_pkg::GRADE_LIMIT : quotient;
      grade_in = num_ff[acst_pkg::NUM_W-1] ? -acst_pkg::GRADE_W'(quo_sat)
                                            : acst_pkg::GRADE_W'(quo_sat);
      peak_grd_in = peak_grd_ff;
      if ($signed(grade_ff) > $signed({1'b0, peak_grd_ff})) begin
         peak_grd_in = grade_ff[acst_pkg::PEAK_GRD_W-1:0];
      end
      status.grade_ok = dist_grow_ff && (num_ff[acst_pkg::NUM_W-1] ||
                        ({{(acst_pkg::LIMIT_W-acst_pkg::NUM_W){1'b0}}, num_ff} < limit_ff));
      status.div_done = div_done;
   end

   acst_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_mag[acst_pkg::MAG_W-1:0]),
      .divisor  (dist_diff_ff[acst_pkg::DIST_W-1:0]),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff   <= 1'b0;
         slot_ff     <= '0;
         climb_ff    <= '0;
         drop_ff     <= '0;
         grade_ff    <= '0;
         peak_alt_ff <= '0;
         peak_grd_ff <= '0;
      end else begin
         if (cmd.load) begin
            primed_ff <= 1'b1;
            slot_ff   <= primed_ff ? slot_in : acst_pkg::SLOT_W'(1);
         end
         if (cmd.product) begin
            climb_ff    <= climb_in;
            drop_ff     <= drop_in;
            peak_alt_ff <= peak_alt_in;
         end
         if (cmd.grade) begin
            grade_ff <= grade_in;
         end
         if (cmd.finish) begin
            peak_grd_ff <= peak_grd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_dist_ff <= req_total_distance;
         in_alt_ff  <= req_sensor_altitude;
      end
      if (cmd.load) begin
         if (!primed_ff) begin
            for (int i = 0; i < acst_pkg::WINDOW; i++) begin
               alt_win_ff[i]  <= in_alt_ff;
               dist_win_ff[i] <= (i == 0) ? in_dist_ff : '0;
            end
            alt_sum_ff   <= {in_alt_ff, {acst_pkg::SLOT_W{1'b0}}};
            dist_sum_ff  <= acst_pkg::DIST_SUM_W'(in_dist_ff);
            prev_dist_ff <= in_dist_ff;
            prev_alt_ff  <= in_alt_ff;
         end else begin
            alt_win_ff[slot_ff]  <= in_alt_ff;
            dist_win_ff[slot_ff] <= in_dist_ff;
            alt_sum_ff  <= alt_sum_ff
                         + {{acst_pkg::SLOT_W{in_alt_ff[acst_pkg::ALT_W-1]}}, in_alt_ff}
                         - {{acst_pkg::SLOT_W{alt_win_ff[slot_ff][acst_pkg::ALT_W-1]}},
                            alt_win_ff[slot_ff]};
            dist_sum_ff <= dist_sum_ff - acst_pkg::DIST_SUM_W'(dist_win_ff[slot_ff])
                         + acst_pkg::DIST_SUM_W'(in_dist_ff);
         end
      end
      if (cmd.means) begin
         mean_alt_ff  <= alt_sum_ff[acst_pkg::ALT_SUM_W-1:acst_pkg::SLOT_W];
         mean_dist_ff <= dist_sum_ff[acst_pkg::DIST_SUM_W-1:acst_pkg::SLOT_W];
         alt_diff_ff  <= alt_diff_in;
         dist_diff_ff <= dist_diff_in;
         dist_grow_ff <= !dist_diff_in[acst_pkg::DIST_DIFF_W-1] && (dist_diff_in != '0);
      end
      if (cmd.product) begin
         num_ff       <= num_in;
         limit_ff     <= limit_in;
         prev_alt_ff  <= mean_alt_ff;
         prev_dist_ff <= mean_dist_ff;
      end
      if (cmd.finish) begin
         rsp_smoothed_altitude <= mean_alt_ff;
         rsp_grade             <= grade_ff;
         rsp_ascent_total      <= climb_ff;
         rsp_descent_total     <= drop_ff;
         rsp_altitude_peak     <= peak_alt_ff;
         rsp_grade_peak        <= peak_grd_in;
      end
   end

endmodule

// ===== src/acst_control.sv =====
`include "altitude_climb_slope_tracker_defines.svh"

module acst_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output acst_pkg::cmd_type    cmd,
   input  acst_pkg::status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MEANS,
      S_PRODUCT,
      S_TEST,
      S_DIV,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_MEANS;
         end
         S_MEANS: begin
            cmd.means = 1'b1;
            state_in  = S_PRODUCT;
         end
         S_PRODUCT: begin
            cmd.product = 1'b1;
            state_in    = S_TEST;
         end
         S_TEST: begin
            if (status.grade_ok) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.grade = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ACST_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.finish, !rsp_valid_ff || rsp_ready)
   `ACST_ASSERT_NOW(a_done_in_div, clock, reset, status.div_done, state_ff == S_DIV)
   `ACST_ASSERT_NEXT(a_one_request, clock, reset, req_valid && req_ready, !req_ready)
   `ACST_ASSERT_NEXT(a_result_follows, clock, reset, cmd.finish, rsp_valid_ff)

endmodule

// ===== src/altitude_climb_slope_tracker.sv =====
// a request runs capture, load, means, product and test; a grade update adds the divider
// the 28-step serial grade divider runs only when the grade test passes; one request at a time
// a held result stalls the next request in its finish state
// reset: synchronous active high, clears control, totals, peaks, grade and max_slope (1000)
// the windows are loaded on the first request after reset
module altitude_climb_slope_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [acst_pkg::DIST_W-1:0]         req_total_distance,
   input  logic signed [acst_pkg::ALT_W-1:0]   req_sensor_altitude,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [acst_pkg::ALT_W-1:0]   rsp_smoothed_altitude,
   output logic signed [acst_pkg::GRADE_W-1:0] rsp_grade,
   output logic [31:0]                         rsp_ascent_total,
   output logic [31:0]                         rsp_descent_total,
   output logic [acst_pkg::PEAK_ALT_W-1:0]     rsp_altitude_peak,
   output logic [acst_pkg::PEAK_GRD_W-1:0]     rsp_grade_peak,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [acst_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   acst_pkg::cmd_type            cmd;
   acst_pkg::status_type         status;
   logic [acst_pkg::SLOPE_W-1:0] max_slope_ff;
   logic                         csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[acst_pkg::CSR_ADDR_W-1] == acst_pkg::REG_MAX_SLOPE);
   assign csr_prdata = csr_hit ? 32'(max_slope_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_slope_ff <= acst_pkg::SLOPE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         max_slope_ff <= csr_pwdata[acst_pkg::SLOPE_W-1:0];
      end
   end

   acst_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   acst_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .max_slope             (max_slope_ff),
      .req_total_distance    (req_total_distance),
      .req_sensor_altitude   (req_sensor_altitude),
      .rsp_smoothed_altitude (rsp_smoothed_altitude),
      .rsp_grade             (rsp_grade),
      .rsp_ascent_total      (rsp_ascent_total),
      .rsp_descent_total     (rsp_descent_total),
      .rsp_altitude_peak     (rsp_altitude_peak),
      .rsp_grade_peak        (rsp_grade_peak)
   );

endmodule

// ===== verif/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import acst_pkg::*;

   localparam int REG_SPARE = 1;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_SLOPE = CSR_ADDR_W'(4 * REG_MAX_SLOPE);
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = CSR_ADDR_W'(4 * REG_SPARE);
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int HOLD_AFTER = 300;
   localparam int HOLD_CYCLES = 400;
   localparam longint TOTAL_CEIL = 64'hFFFF_FFFF;
   localparam longint GRADE_CAP = 10000;
   localparam int SLOPE_TOP = (1 << SLOPE_W) - 1;

   typedef enum {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_e;

   typedef struct {
      logic signed [ALT_W-1:0]   smoothed;
      logic signed [GRADE_W-1:0] grade;
      logic [31:0]               ascent;
      logic [31:0]               descent;
      logic [PEAK_ALT_W-1:0]     alt_peak;
      logic [PEAK_GRD_W-1:0]     grade_peak;
   } reading_t;

   class climb_ledger;
      logic [SLOPE_W-1:0] slope_limit = SLOPE_RESET;
      longint alt_ring[WINDOW];
      longint odo_ring[WINDOW];
      longint alt_total, odo_total, last_mean_alt, last_mean_odo;
      longint ascent, descent, grade_now, alt_top, grade_top;
      int slot;
      bit primed;
      reading_t expected_readings[$];
      int errors;

      function void write_reg(int index, logic [31:0] value);
         if (index == REG_MAX_SLOPE) slope_limit = value[SLOPE_W-1:0];
      endfunction

      function void note_sample(logic [DIST_W-1:0] odo_in, logic signed [ALT_W-1:0] alt_in);
         longint alt, odo, mean_alt, mean_odo, alt_step, odo_step, num, mag;
         reading_t r;
         alt = alt_in;
         odo = odo_in;
         // first sample seeds the altitude window and the previous means
         if (!primed) begin
            foreach (alt_ring[i]) begin
               alt_ring[i] = alt;
               odo_ring[i] = 0;
            end
            alt_total = alt * WINDOW;
            odo_total = 0;
            slot = 0;
            last_mean_odo = odo;
            last_mean_alt = alt;
            primed = 1;
         end
         alt_total += alt - alt_ring[slot];
         odo_total += odo - odo_ring[slot];
         alt_ring[slot] = alt;
         odo_ring[slot] = odo;

         mean_alt = alt_total / WINDOW;
         if (alt_total % WINDOW != 0 && alt_total < 0) mean_alt -= 1;
         mean_odo = odo_total / WINDOW;
         alt_step = mean_alt - last_mean_alt;
         odo_step = mean_odo - last_mean_odo;

         if (alt_step >= 0) begin
            ascent = (ascent + alt_step > TOTAL_CEIL) ? TOTAL_CEIL : ascent + alt_step;
         end else begin
            descent = (descent - alt_step > TOTAL_CEIL) ? TOTAL_CEIL : descent - alt_step;
         end

         if (odo_step > 0) begin
            num = alt_step * 1000;
            if (num < longint'(slope_limit) * odo_step) begin
               mag = (num < 0 ? -num : num) / odo_step;
               grade_now = (num < 0) ? -mag : mag;
               if (grade_now > GRADE_CAP) grade_now = GRADE_CAP;
               if (grade_now < -GRADE_CAP) grade_now = -GRADE_CAP;
            end
         end

         if (mean_alt > alt_top) alt_top = mean_alt & ((longint'(1) << PEAK_ALT_W) - 1);
         if (grade_now > grade_top) grade_top = grade_now & ((longint'(1) << PEAK_GRD_W) - 1);

         last_mean_odo = mean_odo;
         last_mean_alt = mean_alt;
         slot = (slot + 1) % WINDOW;

         r.smoothed = mean_alt[ALT_W-1:0];
         r.grade = grade_now[GRADE_W-1:0];
         r.ascent = ascent[31:0];
         r.descent = descent[31:0];
         r.alt_peak = alt_top[PEAK_ALT_W-1:0];
         r.grade_peak = grade_top[PEAK_GRD_W-1:0];
         expected_readings.push_back(r);
      endfunction

      function void compare_field(string name, logic signed [32:0] want,
                                  logic signed [32:0] seen);
         if (seen !== want) begin
            errors++;
            $display("%0t %s: expected %0d, got %0d", $time, name, want, seen);
         end
      endfunction

      function void check_reading(reading_t got);
         reading_t want;
         if (expected_readings.size() == 0) begin
            errors++;
            $display("%0t unexpected result: smoothed_altitude %0d, grade %0d",
                     $time, got.smoothed, got.grade);
            return;
         end
         want = expected_readings.pop_front();
         compare_field("smoothed_altitude", want.smoothed, got.smoothed);
         compare_field("grade", want.grade, got.grade);
         compare_field("ascent_total", want.ascent, got.ascent);
         compare_field("descent_total", want.descent, got.descent);
         compare_field("altitude_peak", want.alt_peak, got.alt_peak);
         compare_field("grade_peak", want.grade_peak, got.grade_peak);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [DIST_W-1:0]          req_total_distance;
   logic signed [ALT_W-1:0]    req_sensor_altitude;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [ALT_W-1:0]    rsp_smoothed_altitude;
   logic signed [GRADE_W-1:0]  rsp_grade;
   logic [31:0]                rsp_ascent_total;
   logic [31:0]                rsp_descent_total;
   logic [PEAK_ALT_W-1:0]      rsp_altitude_peak;
   logic [PEAK_GRD_W-1:0]      rsp_grade_peak;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_W-1:0]      csr_paddr;
   logic [31:0]                csr_pwdata;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   climb_ledger ledger = new();
   int requests_taken = 0;
   logic [DIST_W-1:0] odometer;
   logic signed [ALT_W-1:0] baro;

   altitude_climb_slope_tracker dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_total_distance    (req_total_distance),
      .req_sensor_altitude   (req_sensor_altitude),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_smoothed_altitude (rsp_smoothed_altitude),
      .rsp_grade             (rsp_grade),
      .rsp_ascent_total      (rsp_ascent_total),
      .rsp_descent_total     (rsp_descent_total),
      .rsp_altitude_peak     (rsp_altitude_peak),
      .rsp_grade_peak        (rsp_grade_peak),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      reading_t got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            ledger.note_sample(req_total_distance, req_sensor_altitude);
            requests_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            got.smoothed = rsp_smoothed_altitude;
            got.grade = rsp_grade;
            got.ascent = rsp_ascent_total;
            got.descent = rsp_descent_total;
            got.alt_peak = rsp_altitude_peak;
            got.grade_peak = rsp_grade_peak;
            ledger.check_reading(got);
         end
      end
   end

   // result side: stall pattern plus one long hold-off
   initial begin
      rx_mode_e mode;
      int phase_left;
      bit held;
      rsp_ready = 1'b0;
      mode = RX_STREAM;
      phase_left = 0;
      held = 0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!held && requests_taken >= HOLD_AFTER) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (phase_left == 0) begin
               mode = rx_mode_e'($urandom_range(0, 2));
               phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            case (mode)
               RX_STREAM: rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_request(input logic [DIST_W-1:0] odo, input logic signed [ALT_W-1:0] alt);
      req_valid <= 1'b1;
      req_total_distance <= odo;
      req_sensor_altitude <= alt;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain_results();
      while (ledger.expected_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_slope_limit(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      ledger.write_reg(addr >> 2, value);
      @(negedge clock);
      // read back the limit
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_MAX_SLOPE;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[SLOPE_W-1:0] !== ledger.slope_limit) begin
         ledger.errors++;
         $display("%0t max_slope readback: expected %0d, got %0d",
                  $time, ledger.slope_limit, csr_prdata[SLOPE_W-1:0]);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic void next_sample();
      int pick;
      int climb;
      longint level;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         // mostly a plausible track, sometimes standing still
         if ($urandom_range(0, 6) != 0) odometer += $urandom_range(1, 400);
         if (pick < 8) begin
            climb = $urandom_range(0, 6000);
            climb -= 3000;
         end else begin
            climb = $urandom_range(0, 400);
            climb -= 200;
         end
         level = longint'(baro) + climb;
         if (level < -5000) level = -5000;
         if (level > 90000) level = 90000;
         baro = ALT_W'(level);
      end else if (pick < 90) begin
         baro = ALT_W'($urandom);
      end else begin
         odometer = $urandom;
         climb = $urandom_range(0, 95000);
         climb -= 5000;
         baro = ALT_W'(climb);
      end
   endfunction

   task automatic run_random(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            next_sample();
            send_request(odometer, baro);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
      req_valid <= 1'b0;
   endtask

   task automatic run_directed();
      // default limit, first sample seeds the windows
      send_request(32'd1000, -18'sd5000);
      send_request(32'd1000, -18'sd5000);
      send_request(32'd1040, -18'sd4990);
      send_request(32'd1100, -18'sd4000);
      send_request(32'd1400, -18'sd6000);
      send_request(32'd1400, 18'sh1FFFF);
      send_request(32'd1500, 18'sh20000);
      send_request(32'hFFFF_FFFF, 18'sd90000);
      send_request(32'd0, 18'sd0);
      send_request(32'h8000_0000, -18'sd1);
      send_request(32'h5555_5555, 18'sh15555);
      req_valid <= 1'b0;
      drain_results();
      // spare register must be ignored, then open the limit past the grade range
      set_slope_limit(ADDR_SPARE, 32'h0000_0005);
      set_slope_limit(ADDR_MAX_SLOPE, 32'hFFFF_FFFF);
      send_request(32'd2000, 18'sd0);
      send_request(32'd2001, 18'sd90000);
      send_request(32'd2002, 18'sd90000);
      send_request(32'd2010, 18'sd90000);
      send_request(32'd2011, -18'sd5000);
      req_valid <= 1'b0;
      drain_results();
      // zero limit: only falling grades pass
      set_slope_limit(ADDR_MAX_SLOPE, 32'd0);
      send_request(32'd3000, 18'sd0);
      send_request(32'd3200, 18'sd2000);
      send_request(32'd3400, -18'sd3000);
      send_request(32'd3400, -18'sd3000);
      req_valid <= 1'b0;
      drain_results();
   endtask

   initial begin
      int unsigned slope_plan[6];
      logic [31:0] word;
      reset = 1'b1;
      req_valid = 1'b0;
      req_total_distance = '0;
      req_sensor_altitude = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      slope_plan = '{10000, SLOPE_TOP, 0, 1, 1000, 0};
      slope_plan[5] = $urandom_range(0, SLOPE_TOP);
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      odometer = $urandom_range(0, 100000);
      baro = 18'sd1200;
      foreach (slope_plan[p]) begin
         word = $urandom;
         word[SLOPE_W-1:0] = SLOPE_W'(slope_plan[p]);
         set_slope_limit(ADDR_MAX_SLOPE, word);
         run_random(ITEMS_PER_PHASE);
         drain_results();
      end
      if (ledger.errors == 0 && ledger.expected_readings.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
